// ----- design/tcpd_pkg.sv -----
// Package: telnet command codes, COM-port option codes and the decoder result type.
`timescale 1ns / 1ps
`default_nettype none
package tcpd_pkg;

    localparam logic [7:0] IAC      = 8'd255;
    localparam logic [7:0] WILL     = 8'd251;
    localparam logic [7:0] SB       = 8'd250;
    localparam logic [7:0] SE       = 8'd240;
    localparam logic [7:0] CPO      = 8'd44;
    localparam logic [7:0] SETPAR   = 8'd3;
    localparam logic [7:0] SETCTL   = 8'd5;
    localparam logic [7:0] PAR_VAL_NONE = 8'd1;
    localparam logic [7:0] PAR_VAL_ODD  = 8'd2;
    localparam logic [7:0] PAR_VAL_EVEN = 8'd3;
    localparam logic [7:0] DTR_ON   = 8'd8;
    localparam logic [7:0] DTR_OFF  = 8'd9;
    localparam logic [7:0] RTS_ON   = 8'd11;
    localparam logic [7:0] RTS_OFF  = 8'd12;

    localparam logic [1:0] PARITY_NONE = 2'd0;
    localparam logic [1:0] PARITY_ODD  = 2'd1;
    localparam logic [1:0] PARITY_EVEN = 2'd2;

    localparam logic [3:0] WORD_BITS_PLAIN  = 4'd8;
    localparam logic [3:0] WORD_BITS_PARITY = 4'd9;

    typedef struct packed {
        logic       send_valid;
        logic [7:0] send_byte;
        logic [1:0] parity_mode;
        logic       dtr_level;
        logic       rts_level;
    } tcpd_result_t;

endpackage
`default_nettype wire

// ----- design/tcpd_core.sv -----
// Decode phase machine and line settings; gives the result for the byte being stepped.
`timescale 1ns / 1ps
`default_nettype none
module tcpd_core (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  step,
    input  wire logic [7:0]            data,
    output tcpd_pkg::tcpd_result_t     result
);
    import tcpd_pkg::*;

    typedef enum logic [3:0] {
        PH_DATA    = 4'd0,
        PH_IAC     = 4'd1,
        PH_OPT     = 4'd2,
        PH_SB      = 4'd3,
        PH_SB_CPO  = 4'd4,
        PH_SKIP    = 4'd5,
        PH_SB_IAC  = 4'd6,
        PH_PAR     = 4'd7,
        PH_CTL     = 4'd8
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic [1:0] parity_reg, parity_next;
    logic       dtr_reg, dtr_next;
    logic       rts_reg, rts_next;
    logic       send;
    logic [7:0] sbyte;

    always_comb
    begin
        phase_next  = phase_reg;
        parity_next = parity_reg;
        dtr_next    = dtr_reg;
        rts_next    = rts_reg;
        send        = 1'b0;
        sbyte       = 8'd0;
        unique case (phase_reg)
            PH_IAC:
            begin
                if (data == IAC)
                begin
                    send       = 1'b1;
                    sbyte      = data;
                    phase_next = PH_DATA;
                end
                else if (data == SB)
                    phase_next = PH_SB;
                else if (data >= WILL)
                    phase_next = PH_OPT;
                else
                    phase_next = PH_DATA;
            end
            PH_OPT:
                phase_next = PH_DATA;
            PH_SB:
                phase_next = (data == CPO) ? PH_SB_CPO : PH_SKIP;
            PH_SB_CPO:
            begin
                if (data == SETPAR)
                    phase_next = PH_PAR;
                else if (data == SETCTL)
                    phase_next = PH_CTL;
                else
                    phase_next = PH_SKIP;
            end
            PH_SKIP:
            begin
                if (data == IAC)
                    phase_next = PH_SB_IAC;
            end
            PH_SB_IAC:
            begin
                if (data == SE)
                    phase_next = PH_DATA;
                else if (data == SB)
                    phase_next = PH_SB;
                else if (data != IAC)
                    phase_next = PH_SKIP;
            end
            PH_PAR:
            begin
                phase_next = PH_SKIP;
                if (data == PAR_VAL_NONE)
                    parity_next = PARITY_NONE;
                else if (data == PAR_VAL_ODD)
                    parity_next = PARITY_ODD;
                else if (data == PAR_VAL_EVEN)
                    parity_next = PARITY_EVEN;
            end
            PH_CTL:
            begin
                phase_next = PH_SKIP;
                if (data == DTR_ON)
                    dtr_next = 1'b0;
                else if (data == DTR_OFF)
                    dtr_next = 1'b1;
                else if (data == RTS_ON)
                    rts_next = 1'b0;
                else if (data == RTS_OFF)
                    rts_next = 1'b1;
            end
            default:
            begin
                if (data == IAC)
                    phase_next = PH_IAC;
                else
                begin
                    phase_next = PH_DATA;
                    send       = 1'b1;
                    sbyte      = data;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_DATA;
            parity_reg <= PARITY_NONE;
            dtr_reg    <= 1'b1;
            rts_reg    <= 1'b0;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            parity_reg <= parity_next;
            dtr_reg    <= dtr_next;
            rts_reg    <= rts_next;
        end
    end

    assign result.send_valid  = send;
    assign result.send_byte   = sbyte;
    assign result.parity_mode = parity_next;
    assign result.dtr_level   = dtr_next;
    assign result.rts_level   = rts_next;

endmodule
`default_nettype wire

// ----- design/telnet_com_port_option_decoder_unit.sv -----
// Top level: host telnet stream decoder with input and result registers.
// Takes one byte of the host-to-serial telnet stream per transfer and returns one result per
// byte: an optional byte for the UART transmitter and the line settings (parity, word length,
// active-low DTR and RTS) after that byte. A byte passes through an input register, is decoded
// by the phase machine and lands in the result register, and one byte is taken every cycle
// while results are taken, since the phase machine steps once per byte.
// After reset: plain data phase, no parity, 8-bit words, DTR high, RTS low.
`timescale 1ns / 1ps
`default_nettype none
module telnet_com_port_option_decoder_unit (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output wire logic       in_ready,
    input  wire logic [7:0] in_byte,
    output wire logic       out_valid,
    input  wire logic       out_ready,
    output wire logic       send_valid,
    output wire logic [7:0] send_byte,
    output wire logic [1:0] parity_mode,
    output wire logic [3:0] word_bits,
    output wire logic       dtr_level,
    output wire logic       rts_level
);
    import tcpd_pkg::*;

    logic         in_valid_reg;
    logic [7:0]   in_byte_reg;
    logic         res_valid_reg;
    tcpd_result_t res_reg;
    tcpd_result_t res_next;
    logic         advance;

    assign advance  = in_valid_reg && (!res_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    tcpd_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .data   (in_byte_reg),
        .result (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                in_valid_reg <= in_valid;
            if (advance)
                res_valid_reg <= 1'b1;
            else if (out_ready)
                res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            in_byte_reg <= in_byte;
        if (advance)
            res_reg <= res_next;
    end

    assign out_valid   = res_valid_reg;
    assign send_valid  = res_reg.send_valid;
    assign send_byte   = res_reg.send_byte;
    assign parity_mode = res_reg.parity_mode;
    assign word_bits   = (res_reg.parity_mode != PARITY_NONE) ? WORD_BITS_PARITY
                                                              : WORD_BITS_PLAIN;
    assign dtr_level   = res_reg.dtr_level;
    assign rts_level   = res_reg.rts_level;

`ifndef NO_ASSERTIONS
    // both stages full and result stalled: no new transfer
    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && res_valid_reg && !out_ready) |-> !in_ready)
        else $error("input taken while pipeline stalled");

    // a stalled result keeps its settings
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(res_reg)))
        else $error("stalled result changed");

    a_quiet_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !send_valid) |-> (send_byte == 8'd0))
        else $error("non-zero byte without send");

    a_parity_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (parity_mode == PARITY_NONE || parity_mode == PARITY_ODD
                       || parity_mode == PARITY_EVEN))
        else $error("illegal parity code");
`endif

endmodule
`default_nettype wire

// ----- tb/testbench.sv -----
// Testbench for the telnet COM-port option decoder: byte stream driver, result checker.
`timescale 1ns / 1ps
module testbench;
    import tcpd_pkg::*;

    typedef enum logic [3:0] {
        PH_DATA, PH_IAC, PH_OPTION, PH_SB, PH_SB_CPO, PH_SKIP, PH_SKIP_IAC,
        PH_PARITY_VAL, PH_CONTROL_VAL
    } decode_phase_t;

    typedef struct packed {
        logic       send_valid;
        logic [7:0] send_byte;
        logic [1:0] parity_mode;
        logic [3:0] word_bits;
        logic       dtr_level;
        logic       rts_level;
    } line_result_t;

    localparam int ITEM_TARGET = 1450;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [7:0] in_byte = 8'd0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic       send_valid;
    logic [7:0] send_byte;
    logic [1:0] parity_mode;
    logic [3:0] word_bits;
    logic       dtr_level;
    logic       rts_level;

    // shadow copy of the decoder state
    decode_phase_t stream_phase = PH_DATA;
    logic [1:0]    parity_state = PARITY_NONE;
    logic          dtr_state = 1'b1;
    logic          rts_state = 1'b0;

    logic [7:0]   byte_q[$];
    line_result_t line_q[$];
    int           total_bytes = 0;
    int           bytes_in = 0;
    int           results_out = 0;
    int           bytes_sent = 0;
    int           parity_writes = 0;
    int           pin_writes = 0;
    int           error_count = 0;
    int           send_idle_pct;
    int           recv_idle_pct;

    telnet_com_port_option_decoder_unit uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_byte     (in_byte),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .send_valid  (send_valid),
        .send_byte   (send_byte),
        .parity_mode (parity_mode),
        .word_bits   (word_bits),
        .dtr_level   (dtr_level),
        .rts_level   (rts_level)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic line_result_t decode_byte(input logic [7:0] b);
        line_result_t r;
        r.send_valid = 1'b0;
        r.send_byte  = 8'd0;
        case (stream_phase)
            PH_IAC:
            begin
                if (b == IAC)
                begin
                    r.send_valid = 1'b1;
                    r.send_byte  = b;
                    stream_phase = PH_DATA;
                end
                else if (b == SB)
                    stream_phase = PH_SB;
                else if (b >= WILL)
                    stream_phase = PH_OPTION;
                else
                    stream_phase = PH_DATA;
            end
            PH_OPTION:
                stream_phase = PH_DATA;
            PH_SB:
                stream_phase = (b == CPO) ? PH_SB_CPO : PH_SKIP;
            PH_SB_CPO:
                stream_phase = (b == SETPAR) ? PH_PARITY_VAL :
                               (b == SETCTL) ? PH_CONTROL_VAL : PH_SKIP;
            PH_SKIP:
            begin
                if (b == IAC)
                    stream_phase = PH_SKIP_IAC;
            end
            PH_SKIP_IAC:
            begin
                if (b != IAC)
                    stream_phase = (b == SE) ? PH_DATA : (b == SB) ? PH_SB : PH_SKIP;
            end
            PH_PARITY_VAL:
            begin
                stream_phase = PH_SKIP;
                parity_writes++;
                if (b == PAR_VAL_NONE)
                    parity_state = PARITY_NONE;
                else if (b == PAR_VAL_ODD)
                    parity_state = PARITY_ODD;
                else if (b == PAR_VAL_EVEN)
                    parity_state = PARITY_EVEN;
            end
            PH_CONTROL_VAL:
            begin
                stream_phase = PH_SKIP;
                pin_writes++;
                if (b == DTR_ON)
                    dtr_state = 1'b0;
                else if (b == DTR_OFF)
                    dtr_state = 1'b1;
                else if (b == RTS_ON)
                    rts_state = 1'b0;
                else if (b == RTS_OFF)
                    rts_state = 1'b1;
            end
            default:
            begin
                if (b == IAC)
                    stream_phase = PH_IAC;
                else
                begin
                    stream_phase = PH_DATA;
                    r.send_valid = 1'b1;
                    r.send_byte  = b;
                end
            end
        endcase
        r.parity_mode = parity_state;
        r.word_bits   = (parity_state != PARITY_NONE) ? WORD_BITS_PARITY : WORD_BITS_PLAIN;
        r.dtr_level   = dtr_state;
        r.rts_level   = rts_state;
        return r;
    endfunction

    task automatic compare_field(input string field, input int unsigned want,
                                 input int unsigned got);
        if (want != got)
        begin
            error_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        end
    endtask

    task automatic push_bytes(input logic [7:0] seq[]);
        foreach (seq[i])
            byte_q.push_back(seq[i]);
    endtask

    task automatic push_subneg_tail();
        int n;
        n = $urandom_range(0, 2);
        repeat (n)
            byte_q.push_back(8'($urandom_range(0, 255)));
        push_bytes('{IAC, SE});
    endtask

    task automatic build_random_stream();
        int          pick;
        int          n;
        logic [7:0]  v;
        while (byte_q.size() < ITEM_TARGET)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 30)
            begin
                n = $urandom_range(1, 4);
                repeat (n)
                    byte_q.push_back(8'($urandom_range(0, 254)));
            end
            else if (pick < 40)
                push_bytes('{IAC, IAC});
            else if (pick < 50)
                push_bytes('{IAC, 8'($urandom_range(WILL, 254)), 8'($urandom_range(0, 255))});
            else if (pick < 55)
                push_bytes('{IAC, 8'($urandom_range(0, SB - 1))});
            else if (pick < 75)
            begin
                v = ($urandom_range(0, 99) < 80) ? 8'($urandom_range(0, 3))
                                                 : 8'($urandom_range(0, 255));
                push_bytes('{IAC, SB, CPO, SETPAR, v});
                push_subneg_tail();
            end
            else if (pick < 90)
            begin
                case ($urandom_range(0, 4))
                    0: v = DTR_ON;
                    1: v = DTR_OFF;
                    2: v = RTS_ON;
                    3: v = RTS_OFF;
                    default: v = 8'($urandom_range(0, 255));
                endcase
                push_bytes('{IAC, SB, CPO, SETCTL, v});
                push_subneg_tail();
            end
            else
            begin
                // noise: raw bytes, foreign or unknown subnegotiations, cut-off sequences
                case ($urandom_range(0, 3))
                    0:
                    begin
                        n = $urandom_range(1, 6);
                        repeat (n)
                            byte_q.push_back(8'($urandom_range(0, 255)));
                    end
                    1:
                    begin
                        push_bytes('{IAC, SB, 8'($urandom_range(0, 255)), IAC,
                                     8'($urandom_range(0, 255))});
                        push_subneg_tail();
                    end
                    2:
                    begin
                        push_bytes('{IAC, SB, CPO, 8'($urandom_range(0, 255))});
                        push_subneg_tail();
                    end
                    default:
                        push_bytes('{IAC, SB, CPO, ($urandom_range(0, 1) ? SETPAR : SETCTL)});
                endcase
            end
        end
    endtask

    always_comb
    begin
        if (bytes_in < total_bytes / 3)
        begin
            send_idle_pct = 32;
            recv_idle_pct = 46;
        end
        else if (bytes_in < 2 * total_bytes / 3)
        begin
            send_idle_pct = 46;
            recv_idle_pct = 32;
        end
        else
        begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
    end

    // driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            out_ready <= 1'b0;
        end
        else
        begin
            if (!in_valid || in_ready)
            begin
                if (byte_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    in_valid <= 1'b1;
                    in_byte  <= byte_q.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
            out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // monitor: checks result transfers, then predicts from input transfers
    always @(posedge clk)
    begin
        line_result_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                results_out++;
                if (line_q.size() == 0)
                begin
                    error_count++;
                    $display("%0t: result transfer with none expected, expected none, actual %0d",
                             $time, send_byte);
                end
                else
                begin
                    want = line_q.pop_front();
                    if (want.send_valid)
                        bytes_sent++;
                    compare_field("send_valid", want.send_valid, send_valid);
                    compare_field("send_byte", want.send_byte, send_byte);
                    compare_field("parity_mode", want.parity_mode, parity_mode);
                    compare_field("word_bits", want.word_bits, word_bits);
                    compare_field("dtr_level", want.dtr_level, dtr_level);
                    compare_field("rts_level", want.rts_level, rts_level);
                end
            end
            if (in_valid && in_ready)
            begin
                bytes_in++;
                line_q.push_back(decode_byte(in_byte));
            end
        end
    end

    initial
    begin
        // directed: byte extremes, literal IAC, option drop, other command,
        // foreign SB with IAC IAC and SB restart, parity set with trailing byte, DTR set
        push_bytes('{8'h00, 8'h7F, 8'h80, 8'hFE});
        push_bytes('{IAC, IAC});
        push_bytes('{IAC, WILL, 8'h01});
        push_bytes('{IAC, 8'hF1});
        push_bytes('{IAC, SB, 8'h01, IAC, IAC, IAC, SB, CPO, SETPAR, PAR_VAL_ODD, 8'h55,
                     IAC, SE});
        push_bytes('{IAC, SB, CPO, SETCTL, DTR_ON, IAC, SE});
        build_random_stream();
        total_bytes = byte_q.size();

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        while (bytes_in < total_bytes || line_q.size() > 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("%0d bytes decoded, %0d results checked, %0d bytes sent on", bytes_in,
                 results_out, bytes_sent);
        $display("%0d parity values and %0d control values applied", parity_writes,
                 pin_writes);
        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #2ms;
        $display("timeout at %0t", $time);
        $display("== FAIL ==");
        $finish;
    end

endmodule
